@@ rtl/core/md4_pkg.sv @@
// Shared types, constants, microcode and round helpers for the MD4 digest core.
package md4_pkg;

	// Item kind codes
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_LAST   = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [31:0] MD4_K2   = 32'h5a827999;
	localparam logic [31:0] MD4_K3   = 32'h6ed9eba1;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	localparam logic [5:0] LAST_ROUND = 6'd47;
	localparam logic [5:0] BLOCK_END  = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [1:0] LAST_WORD  = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} digest_t;

	// Microprogram addresses
	typedef enum logic [2:0] {
		ST_WAIT  = 3'd0,
		ST_LOAD  = 3'd1,
		ST_ROUND = 3'd2,
		ST_ADD   = 3'd3,
		ST_PAD   = 3'd4,
		ST_EMIT  = 3'd5
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_BLOCK_FULL = 3'd1,
		C_FIN_ITEM   = 3'd2,
		C_LAST_ROUND = 3'd3,
		C_NOT_FIN    = 3'd4,
		C_LEN_DONE   = 3'd5,
		C_OUT_DONE   = 3'd6
	} cond_t;

	typedef struct packed {
		logic  take;   // accept an input item
		logic  load;   // working regs <= chaining value
		logic  round;  // one MD4 step
		logic  add;    // chaining value += working regs
		logic  pad;    // write one padding / length byte
		logic  emit;   // present a digest word
		cond_t c1;
		step_t t1;
		cond_t c2;
		step_t t2;
		logic  hold;   // stay when no jump is taken, else fall through
	} ctl_t;

	function automatic ctl_t ucode(input step_t s);
		ctl_t w;
		begin
			w = '{take: 1'b0, load: 1'b0, round: 1'b0, add: 1'b0, pad: 1'b0, emit: 1'b0,
				c1: C_NEVER, t1: ST_WAIT, c2: C_NEVER, t2: ST_WAIT, hold: 1'b1};
			unique case (s)
				ST_WAIT: begin
					w.take = 1'b1;
					w.c1 = C_BLOCK_FULL; w.t1 = ST_LOAD;
					w.c2 = C_FIN_ITEM;   w.t2 = ST_PAD;
				end
				ST_LOAD: begin
					w.load = 1'b1;
					w.hold = 1'b0;
				end
				ST_ROUND: begin
					w.round = 1'b1;
					w.c1 = C_LAST_ROUND; w.t1 = ST_ADD;
				end
				ST_ADD: begin
					w.add = 1'b1;
					w.c1 = C_NOT_FIN;  w.t1 = ST_WAIT;
					w.c2 = C_LEN_DONE; w.t2 = ST_EMIT;
					w.hold = 1'b0;
				end
				ST_PAD: begin
					w.pad = 1'b1;
					w.c1 = C_BLOCK_FULL; w.t1 = ST_LOAD;
				end
				ST_EMIT: begin
					w.emit = 1'b1;
					w.c1 = C_OUT_DONE; w.t1 = ST_WAIT;
				end
				default: begin
					w.c1 = C_NEVER; w.t1 = ST_WAIT;
					w.hold = 1'b0;
				end
			endcase
			return w;
		end
	endfunction

	function automatic logic [4:0] shift_amt(input logic [1:0] stage, input logic [1:0] idx);
		logic [4:0] s;
		begin
			case (stage)
				2'd0:    case (idx) 2'd0: s = 5'd3; 2'd1: s = 5'd7; 2'd2: s = 5'd11;
				         default: s = 5'd19; endcase
				2'd1:    case (idx) 2'd0: s = 5'd3; 2'd1: s = 5'd5; 2'd2: s = 5'd9;
				         default: s = 5'd13; endcase
				default: case (idx) 2'd0: s = 5'd3; 2'd1: s = 5'd9; 2'd2: s = 5'd11;
				         default: s = 5'd15; endcase
			endcase
			return s;
		end
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		begin
			t = {v, v} << s;
			return t[63:32];
		end
	endfunction

endpackage

@@ rtl/core/md4_message_digest.sv @@
// MD4 digest core: microcoded sequencer over a block buffer and one round unit.
//
// Hashes a byte stream with MD4. Message items (kind byte or last byte) are
// taken back to back while the core waits. The byte that completes a 64-byte
// block is followed by compression (load, 48 rounds through a single round
// unit, chaining add) during which no item is taken. A finish item (last
// byte, or finish alone) starts the padding: one padding or length byte is
// written per cycle until the block closes, each padded block (one or two)
// is compressed, then the four digest words go out one per accepted
// item, word 0 first, each with its least significant byte as the first
// digest byte. After word 3 is taken the core returns to the initial chaining
// value with an empty length count. Kind 3 is accepted and ignored. Control
// is a six-step program in a constant table; the step counter, a round counter,
// the fill and word counters and a few flags are the only control state.
module md4_message_digest
	import md4_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	output logic    msg_stall,
	input  msg_t    msg,
	output logic    digest_valid,
	input  logic    digest_stall,
	output digest_t digest
);

	step_t       step_q, step_d;
	ctl_t        ctl;
	logic [5:0]  fill_q;        // next byte position in the block
	logic [60:0] msg_len_q;     // bytes in message, wraps mod 2^61
	logic [5:0]  rnd_q;
	logic [1:0]  word_idx_q;
	logic        fin_q;         // finish item seen
	logic        pad_q;         // 0x80 already written
	logic        len_q;         // length bytes under way
	logic [31:0] cv_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] buf_q [16];

	// Microcode fetch
	always_comb begin
		ctl = ucode(step_q);
	end

	// Handshakes
	logic acc, byte_acc, fin_acc, wr_en, out_done;
	assign msg_stall    = !ctl.take;
	assign acc          = ctl.take && msg_valid;
	assign byte_acc     = acc && (msg.kind == KIND_BYTE || msg.kind == KIND_LAST);
	assign fin_acc      = acc && (msg.kind == KIND_LAST || msg.kind == KIND_FINISH);
	assign digest_valid = ctl.emit;
	assign out_done     = ctl.emit && !digest_stall && word_idx_q == LAST_WORD;

	// Padding byte: 0x80, then zeros, then the 64-bit bit count LSB first
	logic [63:0] len_bits;
	logic        len_byte;
	logic [7:0]  pad_val, wr_val;
	assign len_bits = {msg_len_q, 3'b000};
	assign len_byte = pad_q && (fill_q == LEN_POS || len_q);
	always_comb begin
		if (!pad_q) begin
			pad_val = PAD_BYTE;
		end else if (len_byte) begin
			pad_val = len_bits[{fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_val = 8'h00;
		end
	end
	assign wr_en  = byte_acc || ctl.pad;
	assign wr_val = ctl.pad ? pad_val : msg.data_byte;

	// Condition evaluation
	function automatic logic cond_hit(input cond_t c, input logic full, input logic fin,
		input logic last_rnd, input logic nfin, input logic ldone, input logic odone);
		logic r;
		begin
			unique case (c)
				C_NEVER:      r = 1'b0;
				C_BLOCK_FULL: r = full;
				C_FIN_ITEM:   r = fin;
				C_LAST_ROUND: r = last_rnd;
				C_NOT_FIN:    r = nfin;
				C_LEN_DONE:   r = ldone;
				C_OUT_DONE:   r = odone;
				default:      r = 1'b0;
			endcase
			return r;
		end
	endfunction

	logic blk_full, last_rnd, hit1, hit2;
	assign blk_full = wr_en && fill_q == BLOCK_END;
	assign last_rnd = rnd_q == LAST_ROUND;
	assign hit1 = cond_hit(ctl.c1, blk_full, fin_acc, last_rnd, !fin_q, len_q, out_done);
	assign hit2 = cond_hit(ctl.c2, blk_full, fin_acc, last_rnd, !fin_q, len_q, out_done);

	// Next step
	always_comb begin
		if (hit1) begin
			step_d = ctl.t1;
		end else if (hit2) begin
			step_d = ctl.t2;
		end else if (ctl.hold) begin
			step_d = step_q;
		end else begin
			step_d = step_t'(step_q + 3'd1);
		end
	end

	// Round unit: target word rotates through a_q, result lands in b_q
	logic [1:0]  stage;
	logic [3:0]  jdx, xidx;
	logic [31:0] f, k, sum;
	assign stage = rnd_q[5:4];
	assign jdx   = rnd_q[3:0];
	always_comb begin
		case (stage)
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = 32'd0;
				xidx = jdx;
			end
			2'd1: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = MD4_K2;
				xidx = {jdx[1:0], jdx[3:2]};
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = MD4_K3;
				xidx = {jdx[0], jdx[1], jdx[2], jdx[3]};
			end
		endcase
	end
	assign sum = a_q + f + buf_q[xidx] + k;

	// Block buffer, little-endian byte lanes
	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= wr_val;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
		end else if (ctl.round) begin
			a_q <= d_q;
			b_q <= rotl32(sum, shift_amt(stage, jdx[1:0]));
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	// Control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_WAIT;
			fill_q     <= '0;
			msg_len_q  <= '0;
			rnd_q      <= '0;
			word_idx_q <= '0;
			fin_q      <= 1'b0;
			pad_q      <= 1'b0;
			len_q      <= 1'b0;
			cv_q[0]    <= INIT_A;
			cv_q[1]    <= INIT_B;
			cv_q[2]    <= INIT_C;
			cv_q[3]    <= INIT_D;
		end else begin
			step_q <= step_d;
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (byte_acc) begin
				msg_len_q <= msg_len_q + 61'd1;
			end
			if (fin_acc) begin
				fin_q <= 1'b1;
			end
			if (ctl.pad) begin
				pad_q <= 1'b1;
				if (len_byte) begin
					len_q <= 1'b1;
				end
			end
			if (ctl.round) begin
				rnd_q <= last_rnd ? 6'd0 : rnd_q + 6'd1;
			end
			if (ctl.add) begin
				cv_q[0] <= cv_q[0] + a_q;
				cv_q[1] <= cv_q[1] + b_q;
				cv_q[2] <= cv_q[2] + c_q;
				cv_q[3] <= cv_q[3] + d_q;
			end
			if (ctl.emit && !digest_stall) begin
				word_idx_q <= word_idx_q + 2'd1;
			end
			if (out_done) begin
				msg_len_q <= '0;
				fin_q     <= 1'b0;
				pad_q     <= 1'b0;
				len_q     <= 1'b0;
				cv_q[0]   <= INIT_A;
				cv_q[1]   <= INIT_B;
				cv_q[2]   <= INIT_C;
				cv_q[3]   <= INIT_D;
			end
		end
	end

	assign digest.digest_word = cv_q[word_idx_q];
	assign digest.word_index  = word_idx_q;
	assign digest.last_word   = word_idx_q == LAST_WORD;

	// Checks
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (fin_q && pad_q && len_q && fill_q == 6'd0))
		else $error("digest presented before padding finished");

	a_rnd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ST_ROUND) |-> (rnd_q == 6'd0))
		else $error("round counter running outside round step");

	a_rnd_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.round && last_rnd) |=> (step_q == ST_ADD))
		else $error("last round not followed by chaining add");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_done |=> (msg_len_q == 61'd0 && !fin_q && step_q == ST_WAIT && cv_q[0] == INIT_A))
		else $error("state not reinitialized after final digest word");

endmodule

@@ sim/md4_digest_checker.sv @@
// Channel monitor for the MD4 digest core: predicts each digest word and compares.
`timescale 1ns / 100ps

module md4_digest_checker
	import md4_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	input  logic    msg_stall,
	input  msg_t    msg,
	input  logic    digest_valid,
	input  logic    digest_stall,
	input  digest_t digest,
	output int      fail_count,
	output int      words_pending
);

	// Predicted core state
	logic [31:0] chain [4];
	logic [31:0] blk [16];
	logic [5:0]  fill;
	logic [60:0] byte_count;

	digest_t digest_q[$];
	digest_t want;
	int      mismatches = 0;

	initial begin
		fail_count = 0;
		words_pending = 0;
	end

	function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic int md4_shift(input int stage, input int slot);
		int amt;
		case (stage)
			0:       amt = (slot == 0) ? 3 : (slot == 1) ? 7 : (slot == 2) ? 11 : 19;
			1:       amt = (slot == 0) ? 3 : (slot == 1) ? 5 : (slot == 2) ? 9 : 13;
			default: amt = (slot == 0) ? 3 : (slot == 1) ? 9 : (slot == 2) ? 11 : 15;
		endcase
		return amt;
	endfunction

	task automatic md4_restart();
		chain[0] = 32'h67452301;
		chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476;
		fill = '0;
		byte_count = '0;
	endtask

	// 48 steps over the current block; target word rotates A, D, C, B
	task automatic md4_compress();
		logic [31:0] r [4];
		logic [31:0] b, c, d, f, x, k;
		int p, stage, j, w;
		for (int i = 0; i < 4; i++)
			r[i] = chain[i];
		for (int i = 0; i < 48; i++) begin
			p = (4 - (i % 4)) % 4;
			b = r[(p + 1) % 4];
			c = r[(p + 2) % 4];
			d = r[(p + 3) % 4];
			stage = i / 16;
			j = i % 16;
			case (stage)
				0: begin
					f = (b & c) | (~b & d);
					w = j;
					k = 32'h0;
				end
				1: begin
					f = (b & c) | (b & d) | (c & d);
					w = (j % 4) * 4 + j / 4;
					k = MD4_K2;
				end
				default: begin
					f = b ^ c ^ d;
					// 4-bit reversal of the step index
					w = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
					k = MD4_K3;
				end
			endcase
			x = blk[w];
			r[p] = rol32(r[p] + f + x + k, md4_shift(stage, i % 4));
		end
		for (int i = 0; i < 4; i++)
			chain[i] = chain[i] + r[i];
	endtask

	task automatic md4_put(input logic [7:0] v);
		blk[fill[5:2]][fill[1:0] * 8 +: 8] = v;
		if (fill == 6'd63) begin
			md4_compress();
			fill = '0;
		end else begin
			fill = fill + 6'd1;
		end
	endtask

	task automatic md4_absorb(input msg_t m);
		logic [63:0] bits;
		digest_t     word;
		if (m.kind == KIND_BYTE || m.kind == KIND_LAST) begin
			byte_count = byte_count + 61'd1;
			md4_put(m.data_byte);
		end
		if (m.kind == KIND_LAST || m.kind == KIND_FINISH) begin
			bits = {byte_count, 3'b000};
			md4_put(PAD_BYTE);
			while (fill != 6'd56)
				md4_put(8'h00);
			for (int i = 0; i < 8; i++)
				md4_put(bits[8 * i +: 8]);
			for (int i = 0; i < 4; i++) begin
				word.digest_word = chain[i];
				word.word_index = i[1:0];
				word.last_word = (i == 3);
				digest_q.push_back(word);
			end
			md4_restart();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md4_restart();
			digest_q.delete();
		end else begin
			if (msg_valid && !msg_stall)
				md4_absorb(msg);
			if (digest_valid && !digest_stall) begin
				if (digest_q.size() == 0) begin
					$error("digest word %h with no item pending", digest.digest_word);
					mismatches++;
				end else begin
					want = digest_q.pop_front();
					if (digest.digest_word !== want.digest_word) begin
						$error("digest_word expected %h got %h",
							want.digest_word, digest.digest_word);
						mismatches++;
					end
					if (digest.word_index !== want.word_index) begin
						$error("word_index expected %0d got %0d",
							want.word_index, digest.word_index);
						mismatches++;
					end
					if (digest.last_word !== want.last_word) begin
						$error("last_word expected %b got %b",
							want.last_word, digest.last_word);
						mismatches++;
					end
				end
			end
		end
		words_pending <= digest_q.size();
		fail_count <= mismatches;
	end

endmodule

@@ sim/testbench.sv @@
// Top of the MD4 digest simulation: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module testbench
	import md4_pkg::*;
();

	// Kind code the core accepts and drops
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Limit far above the slowest honest run; leave lots of room
	localparam int CYCLE_LIMIT = 400000;
	// Quiet time after the last word: two padded blocks plus slack
	localparam int TAIL_CYCLES = 300;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    msg_valid;
	logic    msg_stall;
	msg_t    msg;
	logic    digest_valid;
	logic    digest_stall;
	digest_t digest;

	int fail_count;
	int words_pending;
	int cycle_count = 0;

	// Sender burst bookkeeping
	int burst_left = 0;
	int gap;

	// Receiver stall pattern state
	int stall_mode = 0;
	int stall_run = 0;

	// Random message bookkeeping
	int n_items = 0;
	int n_msgs = 0;
	int len;

	always #5 clk = ~clk;

	md4_message_digest DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	md4_digest_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.msg_valid     (msg_valid),
		.msg_stall     (msg_stall),
		.msg           (msg),
		.digest_valid  (digest_valid),
		.digest_stall  (digest_stall),
		.digest        (digest),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	// Watchdog: a hang or a lost digest word ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("md4_digest_verification_timeout");
			$display("md4_message_digest verification failed");
			$finish;
		end
	end

	// Receiver: switches between free flow, random stalls, solid stall
	// runs and a toggling pattern, each held for a random stretch
	initial digest_stall = 1'b0;
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_run <= $urandom_range(4, 40);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			0:       digest_stall <= 1'b0;
			1:       digest_stall <= ($urandom_range(0, 2) == 0);
			2:       digest_stall <= 1'b1;
			default: digest_stall <= ~digest_stall;
		endcase
	end

	// Offer one item and hold it until the core takes it. Bursts of random
	// length are separated by random gaps; a zero gap keeps valid high.
	task automatic send_item(input logic [1:0] k, input logic [7:0] b);
		msg_t m;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				msg_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		m.kind = k;
		m.data_byte = b;
		msg <= m;
		msg_valid <= 1'b1;
		@(posedge clk);
		while (msg_stall)
			@(posedge clk);
	endtask

	// Hold the sender off until every predicted digest word has come out
	task automatic drain();
		msg_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message; data byte is a don't-care on a bare finish
		send_item(KIND_FINISH, 8'hff);
		// Unused kind must be dropped without a trace
		send_item(KIND_NONE, 8'hff);
		send_item(KIND_NONE, 8'h00);
		// "abc", last byte carries the finish
		send_item(KIND_BYTE, 8'h61);
		send_item(KIND_BYTE, 8'h62);
		send_item(KIND_LAST, 8'h63);
		// Single-byte messages at the data extremes
		send_item(KIND_LAST, 8'h00);
		send_item(KIND_LAST, 8'hff);
		// Two empty messages back to back
		send_item(KIND_FINISH, 8'h00);
		send_item(KIND_FINISH, 8'h5a);
		// Extremes as plain bytes, then a bare finish
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hff);
		send_item(KIND_NONE, 8'ha5);
		send_item(KIND_FINISH, 8'h00);
		drain();

		// Random messages: mostly short, some long enough to fill a block,
		// straddle the length field, or need a second padding block.
		// A 61-bit length wrap is out of reach in simulation.
		while (n_items < 160 || n_msgs < 10) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 72)
				: $urandom_range(0, 12);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(KIND_NONE, 8'($urandom_range(0, 255)));
				if (i == len - 1 && $urandom_range(0, 1) == 1) begin
					send_item(KIND_LAST, 8'($urandom_range(0, 255)));
				end else begin
					send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
					if (i == len - 1)
						send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
				end
			end
			if (len == 0)
				send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
			n_items = n_items + len + 1;
			n_msgs++;
			if ($urandom_range(0, 3) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("md4_message_digest verification clean");
		end else begin
			$display("md4_message_digest verification failed");
		end
		$finish;
	end

endmodule
